>>> design/lisl_pkg.sv
package lisl_pkg;

	localparam logic DIR_INC = 1'b0;
	localparam logic DIR_DEC = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic found;
	} lisl_flags_t;

endpackage

>>> design/lisl_cell.sv
module lisl_cell #(
	parameter int VALUE_WIDTH = 32,
	parameter int RUN_W       = 11,
	parameter int INDEX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          dir,
	input  lisl_pkg::lisl_flags_t         in_flags,
	input  logic signed [VALUE_WIDTH-1:0] in_key,
	input  logic [RUN_W-1:0]              in_run,
	output lisl_pkg::lisl_flags_t         out_flags_q,
	output logic signed [VALUE_WIDTH-1:0] out_key_q,
	output logic [RUN_W-1:0]              out_run_q
);

	localparam logic [RUN_W-1:0] CELL_RUN = RUN_W'(INDEX + 1);

	logic signed [VALUE_WIDTH-1:0] tail_q;
	logic                          occ_q;
	logic                          hit;
	logic                          take;
	logic                          clear;

	always_comb begin
		hit   = (dir == lisl_pkg::DIR_DEC) ? (tail_q <= in_key) : (tail_q >= in_key);
		take  = in_flags.valid && !in_flags.found && (in_flags.first || !occ_q || hit);
		clear = in_flags.valid && in_flags.first && !take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= 1'b0;
			out_flags_q <= '0;
		end else if (adv) begin
			if (take) begin
				occ_q <= 1'b1;
			end else if (clear) begin
				occ_q <= 1'b0;
			end
			out_flags_q.valid <= in_flags.valid;
			out_flags_q.first <= in_flags.first;
			out_flags_q.found <= in_flags.found || take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				tail_q <= in_key;
			end
			out_key_q <= in_key;
			out_run_q <= take ? CELL_RUN : in_run;
		end
	end

endmodule

>>> design/lisl_outq.sv
module lisl_outq #(
	parameter int W = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         head_valid,
	input  logic         head_ready,
	output logic [W-1:0] head_data
);

	logic [1:0]   cnt_q;
	logic [W-1:0] data0_q;
	logic [W-1:0] data1_q;
	logic         pop;

	assign pop        = (cnt_q != 2'd0) && head_ready;
	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = data0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && push) begin
			if (cnt_q == 2'd1) begin
				data0_q <= push_data;
			end else begin
				data0_q <= data1_q;
				data1_q <= push_data;
			end
		end else if (pop) begin
			data0_q <= data1_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				data0_q <= push_data;
			end else begin
				data1_q <= push_data;
			end
		end
	end

endmodule

>>> design/streaming_lis_lengths.sv
// An accepted transaction passes DEPTH cell registers, then the output queue register.
// Throughput: one transaction per cycle unless the output queue is full; each sample walks
// the row of DEPTH tail cells, one cell per cycle; later samples follow one cell behind.
// Reset (arst_n, asynchronous): clears every cell's occupancy flag, the pipeline valids,
// the output queue and direction; tail values are not cleared and no clearing pass runs.
module streaming_lis_lengths #(
	parameter int DEPTH       = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic                     cfg_wdata,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// [VALUE_WIDTH-1:0] sample_value
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// [0] first
	input  logic                     s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [RUN_W-1:0] run_length
	output logic [(($clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
	// [0] saturated
	output logic                     m_axis_tuser
);

	localparam int RUN_W = $clog2(DEPTH + 1);
	localparam int OUT_W = ((RUN_W + 7) / 8) * 8;

	logic                          dir_q;
	logic                          adv;
	logic                          q_full;
	logic                          push;
	logic [RUN_W-1:0]              res_run;
	logic                          res_sat;
	logic [RUN_W:0]                head_data;

	lisl_pkg::lisl_flags_t         chain_flags [DEPTH+1];
	logic signed [VALUE_WIDTH-1:0] chain_key   [DEPTH+1];
	logic [RUN_W-1:0]              chain_run   [DEPTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= lisl_pkg::DIR_INC;
		end else if (cfg_wen) begin
			dir_q <= cfg_wdata;
		end
	end

	assign adv           = !q_full;
	assign s_axis_tready = adv;

	assign chain_flags[0].valid = s_axis_tvalid;
	assign chain_flags[0].first = s_axis_tuser;
	assign chain_flags[0].found = 1'b0;
	assign chain_key[0]         = signed'(s_axis_tdata[VALUE_WIDTH-1:0]);
	assign chain_run[0]         = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		lisl_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.RUN_W      (RUN_W),
			.INDEX      (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.dir        (dir_q),
			.in_flags   (chain_flags[k]),
			.in_key     (chain_key[k]),
			.in_run     (chain_run[k]),
			.out_flags_q(chain_flags[k+1]),
			.out_key_q  (chain_key[k+1]),
			.out_run_q  (chain_run[k+1])
		);
	end

	assign push    = adv && chain_flags[DEPTH].valid;
	assign res_sat = !chain_flags[DEPTH].found;
	assign res_run = chain_flags[DEPTH].found ? chain_run[DEPTH] : RUN_W'(DEPTH);

	lisl_outq #(
		.W(RUN_W + 1)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({res_sat, res_run}),
		.full      (q_full),
		.head_valid(m_axis_tvalid),
		.head_ready(m_axis_tready),
		.head_data (head_data)
	);

	assign m_axis_tdata = OUT_W'(head_data[RUN_W-1:0]);
	assign m_axis_tuser = head_data[RUN_W];

endmodule
